### sv/sau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sau_pkg;

   // stack geometry
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_W     = 7;
   localparam int DATA_W      = 32;

   // divider sequencing
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // operation codes
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_DIV  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_MOD  = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SHORT   = 2'd1;
   localparam logic [1:0] STATUS_DIVZERO = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_WB,
      ST_RESP
   } state_type;

   // divider result handed back to the sequencer
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
   } div_result_type;

endpackage

`default_nettype wire

### sv/sau_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sau_div
   import sau_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DATA_W-1:0] dividend,
   input  wire logic signed [DATA_W-1:0] divisor,
   output div_result_type                result
);

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dmag_ff, dmag_in;
   logic                 neg_q_ff, neg_q_in;
   logic                 neg_r_ff, neg_r_in;

   logic [DATA_W:0]      partial;
   logic [DATA_W:0]      trial;

   // one restoring step per cycle on magnitudes
   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dmag_in    = dmag_ff;
      neg_q_in   = neg_q_ff;
      neg_r_in   = neg_r_ff;
      partial    = {rem_ff, quo_ff[DATA_W-1]};
      trial      = partial - {1'b0, dmag_ff};
      if (start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dmag_in    = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_q_in   = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         neg_r_in   = dividend[DATA_W-1];
      end else if (running_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = partial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dmag_ff  <= dmag_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // sign fix: quotient toward zero, remainder follows the dividend
   assign result.done      = done_ff;
   assign result.quotient  = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign result.remainder = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;

endmodule

`default_nettype wire

### sv/stack_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Stack arithmetic unit: a 64-entry stack of signed 32-bit words held in a
// synchronous RAM, with the top entry mirrored in a register. One operation
// is taken at a time. A push, an error and an unused code go from idle to
// the response state, which loads the result register once the output
// side is free. Subtract and multiply first read the second entry from
// RAM, then compute, then write back. Divide and modulo read the second
// entry, then wait on the shared radix-2 divider, which retires one
// quotient bit per cycle over 32 steps, then write back. The next input is
// taken in the cycle after the result is loaded, even while that result
// still waits at the output. The stack RAM needs no clearing after reset.
module stack_arithmetic_unit
   import sau_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_operation,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic signed [DATA_W-1:0]      rsp_top_value,
   output logic [DEPTH_W-1:0]            rsp_stack_depth
);

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0]  top_ff, top_in;
   logic [1:0]         status_ff, status_in;
   logic [2:0]         op_ff, op_in;
   logic [DATA_W-1:0]  res_ff, res_in;
   logic [DATA_W-1:0]  rd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [COUNT_W-1:0] below_idx;
   logic [2*DATA_W-1:0] product;

   logic               div_start;
   div_result_type     div_res;

   sau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (top_ff),
      .result   (div_res)
   );

   assign below_idx = count_ff - COUNT_W'(2);
   assign product   = rd_data_ff * top_ff;
   assign req_stall = (state_ff != ST_IDLE);

   // sequencer: check, read second entry, compute, write back, respond
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      status_in     = status_ff;
      op_in         = op_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      mem_we        = 1'b0;
      mem_waddr     = below_idx[ADDR_W-1:0];
      mem_wdata     = res_ff;
      mem_re        = 1'b0;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               status_in = STATUS_OK;
               state_in  = ST_RESP;
               case (req_operation)
                  OP_PUSH: begin
                     if (count_ff >= COUNT_W'(STACK_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[ADDR_W-1:0];
                        mem_wdata = req_push_value;
                        top_in    = req_push_value;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_SUB, OP_DIV, OP_MUL, OP_MOD: begin
                     if (count_ff < COUNT_W'(2)) begin
                        status_in = STATUS_SHORT;
                     end else if ((req_operation == OP_DIV || req_operation == OP_MOD)
                                  && top_ff == '0) begin
                        status_in = STATUS_DIVZERO;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = ST_EXEC;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_SUB: begin
                  res_in   = rd_data_ff - top_ff;
                  state_in = ST_WB;
               end
               OP_MUL: begin
                  res_in   = product[DATA_W-1:0];
                  state_in = ST_WB;
               end
               OP_DIV, OP_MOD: begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
               default: begin
                  state_in = ST_WB;
               end
            endcase
         end
         ST_DIV: begin
            if (div_res.done) begin
               res_in   = (op_ff == OP_DIV) ? div_res.quotient : div_res.remainder;
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            mem_we   = 1'b1;
            top_in   = res_ff;
            count_in = count_ff - 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_top_in    = (count_ff != '0) ? top_ff : '0;
               rsp_depth_in  = DEPTH_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // stack ram: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[below_idx[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      status_ff     <= status_in;
      op_ff         <= op_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   // result transfer outputs
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;

endmodule

`default_nettype wire
